// File: hdl/ssa_pkg.sv
`timescale 1ns / 1ps

package ssa_pkg;

  // Request kinds as they arrive on the input channel.
  localparam logic [1:0] KIND_STORE = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_LOAD  = 2'd2;

  // Access codes of a result.
  localparam logic [1:0] ACC_WRITE = 2'd0;
  localparam logic [1:0] ACC_READ  = 2'd1;
  localparam logic [1:0] ACC_NONE  = 2'd2;

  // Status codes of a result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Operations handed from the front to the back.
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;
  localparam logic [1:0] OP_RANGE = 2'd3;

  localparam int          CFG_W       = 11;
  localparam logic [10:0] COUNT_RESET = 11'd1024;
  localparam int          ROW_BITS    = 32;

  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] slot;
  } ssa_req_t;

  typedef struct packed {
    logic [9:0]  slot_number;
    logic [12:0] sector;
    logic [1:0]  access;
    logic [1:0]  status;
    logic        last;
  } ssa_res_t;

  typedef struct packed {
    logic [1:0] op;
    logic [9:0] slot;
  } ssa_cmd_t;

endpackage

// File: hdl/ssa_fifo.sv
`timescale 1ns / 1ps

module ssa_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

`ifndef SYNTHESIS
  // A lone pop of a held entry must lower the fill by exactly one.
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !(push && !full)) |=> (count_r == $past(count_r) - 1'b1))
    else $error("fifo fill did not drop on pop");
`endif

endmodule

// File: hdl/ssa_front.sv
`timescale 1ns / 1ps

module ssa_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  ssa_pkg::ssa_req_t in_data,
  output logic              in_full,
  input  logic [10:0]       eff_count,
  output logic              cmd_valid,
  output ssa_pkg::ssa_cmd_t cmd,
  input  logic              cmd_pop
);

  import ssa_pkg::*;

  ssa_cmd_t                 cmd_in;
  logic                     keep;
  logic                     q_full, q_empty;
  logic [$bits(ssa_cmd_t)-1:0] q_dout;

  // Classify the request; the range check needs only the slot count.
  always_comb begin
    cmd_in.slot = in_data.slot;
    cmd_in.op   = OP_ALLOC;
    keep        = 1'b0;
    unique case (in_data.kind) inside
      KIND_STORE: begin
        keep = 1'b1;
      end
      KIND_FREE, KIND_LOAD: begin
        keep = 1'b1;
        if ({1'b0, in_data.slot} >= eff_count) begin
          cmd_in.op = OP_RANGE;
        end else if (in_data.kind == KIND_FREE) begin
          cmd_in.op = OP_FREE;
        end else begin
          cmd_in.op = OP_LOAD;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  ssa_fifo #(
    .WIDTH($bits(ssa_cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (in_push && !q_full && keep),
    .din  (cmd_in),
    .full (q_full),
    .pop  (cmd_pop),
    .dout (q_dout),
    .empty(q_empty)
  );

  assign in_full   = q_full;
  assign cmd_valid = !q_empty;
  assign cmd       = q_dout;

endmodule

// File: hdl/ssa_back.sv
`timescale 1ns / 1ps

module ssa_back #(
  parameter int SLOTS            = 1024,
  parameter int SECTORS_PER_SLOT = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [10:0]       eff_count,
  input  logic              cmd_valid,
  input  ssa_pkg::ssa_cmd_t cmd,
  output logic              cmd_pop,
  output logic              res_push,
  output ssa_pkg::ssa_res_t res,
  input  logic              res_full
);

  import ssa_pkg::*;

  localparam int ROWS      = (SLOTS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LAST_BITS = SLOTS - (ROWS - 1) * ROW_BITS;
  localparam int CNT_W     = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;
  localparam int CMP_W     = (ROW_AW + 5 > 11) ? ROW_AW + 5 : 11;
  localparam logic [12:0] SPS13 = 13'(SECTORS_PER_SLOT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIND = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_ONE  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [10:0]         slot_r, slot_nxt;
  logic [ROW_AW-1:0]   row_r, row_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [1:0]          acc_r, acc_nxt;
  logic [1:0]          st_r, st_nxt;
  logic [ROWS-1:0]     rv_r, rf_r;
  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROW_BITS-1:0] rd_r;
  logic                rdv_r;

  logic [ROW_AW-1:0]   free_row, find_row;
  logic                free_any;
  logic [ROW_BITS-1:0] pad_w, word, bit_mask, new_word;
  logic [4:0]          bit_idx, bit_sel;
  logic [ROW_AW+4:0]   found;
  logic                mem_we;
  logic [12:0]         base_sec;
  logic                emit_last;

  // Lowest row that still holds a free slot.
  always_comb begin
    free_row = '0;
    free_any = 1'b0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (!rf_r[i]) begin
        free_row = ROW_AW'(i);
        free_any = 1'b1;
      end
    end
  end

  assign find_row = (op_r == OP_ALLOC) ? free_row : ROW_AW'(slot_r >> 5);

  // Bits past the last slot of the last row count as used.
  always_comb begin
    for (int j = 0; j < ROW_BITS; j++) begin
      pad_w[j] = (row_r == ROW_AW'(ROWS - 1)) && (j >= LAST_BITS);
    end
  end

  // A row never written reads as all free.
  assign word = (rdv_r ? rd_r : '0) | pad_w;

  always_comb begin
    bit_idx = '0;
    for (int j = ROW_BITS - 1; j >= 0; j--) begin
      if (!word[j]) begin
        bit_idx = 5'(j);
      end
    end
  end

  assign bit_sel  = (op_r == OP_ALLOC) ? bit_idx : slot_r[4:0];
  assign bit_mask = ROW_BITS'(1) << bit_sel;
  assign new_word = (op_r == OP_ALLOC) ? (word | bit_mask) : (word & ~bit_mask);
  assign found    = {row_r, bit_idx};
  assign base_sec = {2'b00, slot_r} * SPS13;
  assign emit_last = (cnt_r == CNT_W'(SECTORS_PER_SLOT - 1));

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    slot_nxt  = slot_r;
    row_nxt   = row_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    st_nxt    = st_r;
    cmd_pop   = 1'b0;
    mem_we    = 1'b0;
    res_push  = 1'b0;
    res.slot_number = slot_r[9:0];
    res.sector      = '0;
    res.access      = ACC_NONE;
    res.status      = st_r;
    res.last        = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          op_nxt   = cmd.op;
          slot_nxt = {1'b0, cmd.slot};
          cnt_nxt  = '0;
          unique case (cmd.op) inside
            OP_ALLOC, OP_FREE: begin
              state_nxt = S_FIND;
            end
            OP_LOAD: begin
              acc_nxt   = ACC_READ;
              state_nxt = S_EMIT;
            end
            default: begin
              st_nxt    = ST_RANGE;
              state_nxt = S_ONE;
            end
          endcase
        end
      end
      S_FIND: begin
        row_nxt = find_row;
        if ((op_r == OP_ALLOC) && !free_any) begin
          slot_nxt  = '0;
          st_nxt    = ST_FULL;
          state_nxt = S_ONE;
        end else begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (op_r == OP_ALLOC) begin
          if (CMP_W'(found) < CMP_W'(eff_count)) begin
            mem_we    = 1'b1;
            slot_nxt  = 11'(found);
            acc_nxt   = ACC_WRITE;
            state_nxt = S_EMIT;
          end else begin
            slot_nxt  = '0;
            st_nxt    = ST_FULL;
            state_nxt = S_ONE;
          end
        end else begin
          mem_we    = 1'b1;
          st_nxt    = ST_OK;
          state_nxt = S_ONE;
        end
      end
      S_EMIT: begin
        res.sector = base_sec + 13'(cnt_r);
        res.access = acc_r;
        res.status = ST_OK;
        res.last   = emit_last;
        if (!res_full) begin
          res_push = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ONE: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rv_r    <= '0;
      rf_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (mem_we) begin
        rv_r[row_r] <= 1'b1;
        rf_r[row_r] <= &new_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    slot_r <= slot_nxt;
    row_r  <= row_nxt;
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    st_r   <= st_nxt;
  end

  // Bitmap rows: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[row_r] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIND) begin
      rd_r  <= mem[find_row];
      rdv_r <= rv_r[find_row];
    end
  end

`ifndef SYNTHESIS
  a_row_has_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD && op_r == OP_ALLOC) |-> (word != '1))
    else $error("row picked for allocation holds no free slot");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.last) |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after the last result");
  a_emit_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.access != ACC_NONE) |-> (res.status == ST_OK))
    else $error("sector result carries an error status");
`endif

endmodule

// File: hdl/swap_slot_allocator_top.sv
`timescale 1ns / 1ps

// Swap slot allocator: a first-fit bitmap of used marks, one per slot.
// Input channel (in_push / in_full / in_data): a request is taken at a rising
// edge with in_push high and in_full low. Store finds the lowest free slot
// below the slot count and marks it used; free clears a mark; load addresses
// a named slot. Kind 3 is taken and dropped without any result.
// Result channel (out_empty / out_pop / out_data): the oldest result sits on
// out_data while out_empty is low and leaves on a rising edge with out_pop.
// Store and load give SECTORS_PER_SLOT sector results, the final one with
// last set; free, a full bitmap and an out-of-range slot give one result.
// Configuration (cfg_valid / cfg_ready / cfg_data) writes the slot count; it
// is always ready and must only be used while no request is in flight.
// A short command queue lets request intake run ahead of the bitmap sequencer.
// At the sequencer a store runs command take, row pick and read, row update,
// then one sector per cycle while the result queue has room; a load skips the
// row steps, and a free gives its one result after the row update. A new
// command is taken only once the sequencer is back in idle.
// Reset clears the queues and row marks and restores a count of 1024; every
// slot reads free afterwards. A stalled receiver fills the result queue, then
// the command queue, which raises in_full; nothing is dropped.
module swap_slot_allocator_top #(
  parameter int SLOTS            = 1024,
  parameter int SECTORS_PER_SLOT = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  ssa_pkg::ssa_req_t in_data,
  output logic              in_full,
  output logic              out_empty,
  input  logic              out_pop,
  output ssa_pkg::ssa_res_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [10:0]       cfg_data
);

  import ssa_pkg::*;

  // Largest count that can matter: the register cannot exceed 2047.
  localparam int          CAP   = (SLOTS < 2047) ? SLOTS : 2047;
  localparam logic [10:0] CAP11 = 11'(CAP);

  logic [CFG_W-1:0] slot_count_r;
  logic [10:0]      eff_count;
  logic             cmd_valid, cmd_pop;
  ssa_cmd_t         cmd;
  logic             res_push, res_full;
  ssa_res_t         res;
  logic [$bits(ssa_res_t)-1:0] res_dout;

  // The slot count register; configuration is always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slot_count_r <= cfg_data;
    end
  end

  // The count in use is capped at the number of slots built.
  assign eff_count = (slot_count_r > CAP11) ? CAP11 : slot_count_r;

  ssa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .eff_count(eff_count),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  ssa_back #(
    .SLOTS           (SLOTS),
    .SECTORS_PER_SLOT(SECTORS_PER_SLOT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .eff_count(eff_count),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full)
  );

  // Result queue decouples the sequencer from a stalling receiver.
  ssa_fifo #(
    .WIDTH($bits(ssa_res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .din  (res),
    .full (res_full),
    .pop  (out_pop),
    .dout (res_dout),
    .empty(out_empty)
  );

  assign out_data = res_dout;

endmodule

// File: test/ssa_checker.sv
`timescale 1ns / 1ps

// Watches the three channels of the slot allocator, keeps its own copy of the
// used bitmap and the slot limit, and checks every result against the oldest
// one still owed.
module ssa_checker #(
  parameter int SLOTS            = 1024,
  parameter int SECTORS_PER_SLOT = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              in_full,
  input  ssa_pkg::ssa_req_t in_data,
  input  logic              out_empty,
  input  logic              out_pop,
  input  ssa_pkg::ssa_res_t out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [10:0]       cfg_data,
  output int                fail_count,
  output int                results_due
);
  import ssa_pkg::*;

  bit          taken [SLOTS];
  logic [10:0] slot_limit;
  ssa_res_t    owed_results[$];

  initial begin
    fail_count  = 0;
    results_due = 0;
  end

  task automatic owe(input logic [9:0] slot_no, input logic [12:0] sector,
                     input logic [1:0] access, input logic [1:0] status,
                     input logic last);
    ssa_res_t r;
    r.slot_number = slot_no;
    r.sector      = sector;
    r.access      = access;
    r.status      = status;
    r.last        = last;
    owed_results.push_back(r);
  endtask

  task automatic owe_sector_run(input logic [9:0] slot_no, input logic [1:0] access);
    for (int i = 0; i < SECTORS_PER_SLOT; i++) begin
      owe(slot_no, 13'(slot_no * SECTORS_PER_SLOT + i), access, ST_OK,
          i == SECTORS_PER_SLOT - 1);
    end
  endtask

  task automatic compute_slot_results(input ssa_req_t req);
    int  usable;
    int  pick;
    bit  found;
    usable = (slot_limit < SLOTS) ? int'(slot_limit) : SLOTS;
    found  = 1'b0;
    pick   = 0;
    case (req.kind) inside
      KIND_STORE: begin
        for (int s = 0; s < usable; s++) begin
          if (!found && !taken[s]) begin
            found = 1'b1;
            pick  = s;
          end
        end
        if (found) begin
          taken[pick] = 1'b1;
          owe_sector_run(10'(pick), ACC_WRITE);
        end else begin
          owe('0, '0, ACC_NONE, ST_FULL, 1'b1);
        end
      end
      KIND_FREE, KIND_LOAD: begin
        if (int'(req.slot) >= usable) begin
          owe(req.slot, '0, ACC_NONE, ST_RANGE, 1'b1);
        end else if (req.kind == KIND_FREE) begin
          taken[req.slot] = 1'b0;
          owe(req.slot, '0, ACC_NONE, ST_OK, 1'b1);
        end else begin
          owe_sector_run(req.slot, ACC_READ);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input ssa_res_t want, input ssa_res_t got);
    if (fail_count < 10) begin
      $display("%0t checker: %s exp slot=%0d sector=%0d acc=%0d st=%0d last=%0d",
               $realtime, what, want.slot_number, want.sector, want.access,
               want.status, want.last);
      $display("%0t checker:    got slot=%0d sector=%0d acc=%0d st=%0d last=%0d",
               $realtime, got.slot_number, got.sector, got.access, got.status,
               got.last);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    ssa_res_t want;
    if (!rst_n) begin
      foreach (taken[i]) taken[i] = 1'b0;
      slot_limit = COUNT_RESET;
      owed_results.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (owed_results.size() == 0) begin
          report("result with nothing owed;", '0, out_data);
        end else begin
          want = owed_results.pop_front();
          if (out_data.slot_number !== want.slot_number || out_data.sector !== want.sector ||
              out_data.access !== want.access || out_data.status !== want.status ||
              out_data.last !== want.last) begin
            report("mismatch;", want, out_data);
          end
        end
      end
      if (cfg_valid && cfg_ready) slot_limit = cfg_data;
      if (in_push && !in_full) compute_slot_results(in_data);
    end
    results_due = owed_results.size();
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the swap slot allocator. All checking lives in the
// checker instance; this module only drives requests, the slot limit and the
// pop side, then reads back the failure count at the end.
module tb_top;
  import ssa_pkg::*;

  // Kind 3 is not a defined request; the block must swallow it silently.
  localparam logic [1:0] KIND_BOGUS = 2'd3;

  // The bitmap read-modify-write plus the command queue means a request that
  // produces no result can still be in flight after the last owed result has
  // gone, so quiet periods are padded by this much.
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_push;
  ssa_req_t    in_data;
  logic        in_full;
  logic        out_empty;
  logic        out_pop;
  ssa_res_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;

  int fail_count;
  int results_due;

  // Shared between the request driver and the pop side. When steady is set
  // neither side inserts random gaps; squeeze asks the pop side for one long
  // hold-off so the result and command queues back up into in_full.
  bit steady;
  bit squeeze;

  always #2 clk = ~clk;

  swap_slot_allocator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ssa_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // Offer one request, starting at a falling edge. Random gaps come first,
  // then push stays high until a rising edge finds in_full low. The task
  // returns at the next falling edge, where the following request may keep
  // push high without it ever dropping in between.
  task automatic send_request(input logic [1:0] kind, input logic [9:0] slot);
    ssa_req_t req;
    req.kind = kind;
    req.slot = slot;
    while (!steady && $urandom_range(0, 99) < 19) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  // Let every owed result drain, then wait out the settle padding so that the
  // block is surely idle.
  task automatic wait_drained();
    in_push <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The slot limit may only change while the block is idle.
  task automatic set_slot_limit(input logic [10:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A random phase. Slots are mostly drawn from zero up to the limit so that
  // frees and loads often hit allocated slots and the out-of-range boundary;
  // the rest span the whole slot field. Bogus kinds do not count toward n.
  task automatic random_phase(input logic [10:0] limit, input int n, input int store_pct);
    int          done;
    int          roll;
    int          top;
    logic [1:0]  kind;
    logic [9:0]  slot;
    done = 0;
    top  = (limit > 1023) ? 1023 : int'(limit);
    while (done < n) begin
      roll = $urandom_range(0, 99);
      if (roll < store_pct) kind = KIND_STORE;
      else if (roll >= 96) kind = KIND_BOGUS;
      else if (roll % 2 == 1) kind = KIND_FREE;
      else kind = KIND_LOAD;
      if ($urandom_range(0, 3) == 0) slot = 10'($urandom_range(0, 1023));
      else slot = 10'($urandom_range(0, top));
      send_request(kind, slot);
      if (kind != KIND_BOGUS) done++;
    end
  endtask

  // Pop side. About 19 percent of the time pop is held low, except while steady.
  // When squeeze is raised it holds pop low for a long counted stretch, once.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    out_pop   = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (squeeze && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= steady || $urandom_range(0, 99) >= 19;
      end
    end
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    steady    = 1'b0;
    squeeze   = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Default limit of 1024: first-fit from an empty bitmap, a load of the
    // topmost slot (never allocated, addresses still come out), a free of a
    // slot that is already free, reuse of a freed slot, and a bogus kind.
    send_request(KIND_STORE, 10'd1023);
    send_request(KIND_STORE, 10'd0);
    send_request(KIND_LOAD, 10'd0);
    send_request(KIND_LOAD, 10'd1023);
    send_request(KIND_FREE, 10'd1023);
    send_request(KIND_FREE, 10'd0);
    send_request(KIND_STORE, 10'd0);
    send_request(KIND_BOGUS, 10'd1023);

    // Limit 2 with both slots taken: the swap is full, and slots at or past
    // the limit are out of range for free and load.
    set_slot_limit(11'd2);
    send_request(KIND_STORE, 10'd0);
    send_request(KIND_FREE, 10'd2);
    send_request(KIND_LOAD, 10'd1023);
    send_request(KIND_FREE, 10'd1);
    send_request(KIND_STORE, 10'd0);
    send_request(KIND_STORE, 10'd0);

    // A limit of zero means no slot exists at all.
    set_slot_limit(11'd0);
    send_request(KIND_STORE, 10'd0);
    send_request(KIND_FREE, 10'd0);
    send_request(KIND_LOAD, 10'd0);

    // Every register bit set: the limit is capped at the slot count.
    set_slot_limit(11'd2047);
    send_request(KIND_LOAD, 10'd1023);
    send_request(KIND_FREE, 10'd1023);
    send_request(KIND_STORE, 10'd0);

    // Single slot.
    set_slot_limit(11'd1);
    send_request(KIND_FREE, 10'd0);
    send_request(KIND_STORE, 10'd0);
    send_request(KIND_STORE, 10'd0);
    send_request(KIND_LOAD, 10'd0);

    // Random part. The first phase runs with no gaps on either side; the
    // full-size phase carries the long pop hold-off.
    set_slot_limit(11'd5);
    steady = 1'b1;
    random_phase(11'd5, 35, 40);
    steady = 1'b0;

    set_slot_limit(11'd40);
    random_phase(11'd40, 40, 75);

    set_slot_limit(11'd1024);
    squeeze = 1'b1;
    random_phase(11'd1024, 35, 45);

    set_slot_limit(11'd1);
    random_phase(11'd1, 25, 40);

    set_slot_limit(11'd2047);
    random_phase(11'd2047, 35, 40);

    set_slot_limit(11'd64);
    random_phase(11'd64, 35, 60);

    set_slot_limit(11'($urandom_range(2, 20)));
    random_phase(11'd20, 35, 40);

    wait_drained();
    if (fail_count == 0 && results_due == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
